// ----- src/b64d_pkg.sv -----
package b64d_pkg;

	// One input word: an ASCII character and the end-of-message mark.
	typedef struct packed {
		logic [7:0] symbol;
		logic       message_end;
	} in_t;

	// One output word.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_valid;
		logic       run_last;
		logic       done_res;
	} out_t;

	localparam int unsigned MaxResults = 3;

	// All results caused by one input word, handed from the decode stage to the buffer.
	typedef struct packed {
		logic [1:0]                 count;
		out_t [MaxResults-1:0]      res;
	} bundle_t;

endpackage

// ----- src/base64_decoder_top.sv -----
// An accepted character word is registered in the input stage, then its results in
// the result buffer. One character word per cycle while the buffer can load; the
// buffer drains one result word per cycle while res_ready is high.
// Reset (arst_n low, asynchronous): clears group count, held sextets, halt flag,
// the input stage and the result buffer; the first message starts clean.
module base64_decoder_top (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           char_valid,
	output logic           char_ready,
	input  b64d_pkg::in_t  char_data,
	output logic           res_valid,
	input  logic           res_ready,
	output b64d_pkg::out_t res_data
);

	logic              valid_s1;
	b64d_pkg::in_t     item_s1;
	logic              can_load;
	logic              advance;
	b64d_pkg::bundle_t bundle;

	assign advance    = valid_s1 && can_load;
	assign char_ready = !valid_s1 || can_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (char_ready) begin
			valid_s1 <= char_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (char_ready && char_valid) begin
			item_s1 <= char_data;
		end
	end

	b64d_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (advance),
		.item   (item_s1),
		.bundle (bundle)
	);

	b64d_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance),
		.bundle    (bundle),
		.can_load  (can_load),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data)
	);

endmodule

// ----- src/b64d_core.sv -----
module b64d_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  b64d_pkg::in_t    item,
	output b64d_pkg::bundle_t bundle
);

	logic [1:0]  group_count_q;
	logic [17:0] held_sextets_q;
	logic        halted_q;

	logic [1:0]  gc_next;
	logic [17:0] held_next;
	logic        halt_next;
	logic [6:0]  code;
	logic [23:0] word;
	logic [1:0]  n;

	// Bit 6 flags a character of the alphabet; bits 5:0 hold its value.
	function automatic logic [6:0] sextet_of(input logic [7:0] ch);
		logic [6:0] r;
		r = 7'd0;
		if (ch >= 8'h41 && ch <= 8'h5A) begin
			r = {1'b1, 6'(ch - 8'h41)};
		end else if (ch >= 8'h61 && ch <= 8'h7A) begin
			r = {1'b1, 6'(ch - 8'h61 + 8'd26)};
		end else if (ch >= 8'h30 && ch <= 8'h39) begin
			r = {1'b1, 6'(ch - 8'h30 + 8'd52)};
		end else if (ch == 8'h2B) begin
			r = {1'b1, 6'd62};
		end else if (ch == 8'h2F) begin
			r = {1'b1, 6'd63};
		end
		return r;
	endfunction

	always_comb begin
		code      = sextet_of(item.symbol);
		gc_next   = group_count_q;
		held_next = held_sextets_q;
		halt_next = halted_q;
		word      = 24'd0;
		n         = 2'd0;
		bundle    = '0;

		if (!halted_q) begin
			if (!code[6]) begin
				halt_next = 1'b1;
			end else if (group_count_q == 2'd3) begin
				word = {held_sextets_q, code[5:0]};
				bundle.res[0].data_byte  = word[23:16];
				bundle.res[0].byte_valid = 1'b1;
				bundle.res[1].data_byte  = word[15:8];
				bundle.res[1].byte_valid = 1'b1;
				bundle.res[2].data_byte  = word[7:0];
				bundle.res[2].byte_valid = 1'b1;
				n         = 2'd3;
				gc_next   = 2'd0;
				held_next = 18'd0;
			end else begin
				held_next = {held_sextets_q[11:0], code[5:0]};
				gc_next   = group_count_q + 2'd1;
			end
		end

		if (item.message_end) begin
			// A partial group of n sextets gives n-1 bytes; leftover bits are dropped.
			if (gc_next == 2'd2) begin
				bundle.res[0].data_byte  = held_next[11:4];
				bundle.res[0].byte_valid = 1'b1;
				n = 2'd1;
			end else if (gc_next == 2'd3) begin
				bundle.res[0].data_byte  = held_next[17:10];
				bundle.res[0].byte_valid = 1'b1;
				bundle.res[1].data_byte  = held_next[9:2];
				bundle.res[1].byte_valid = 1'b1;
				n = 2'd2;
			end
			if (n == 2'd0) begin
				n = 2'd1;
			end
			bundle.res[n - 2'd1].done_res = 1'b1;
			gc_next   = 2'd0;
			held_next = 18'd0;
			halt_next = 1'b0;
		end

		if (n != 2'd0) begin
			bundle.res[n - 2'd1].run_last = 1'b1;
		end
		bundle.count = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_count_q  <= 2'd0;
			held_sextets_q <= 18'd0;
			halted_q       <= 1'b0;
		end else if (load) begin
			group_count_q  <= gc_next;
			held_sextets_q <= held_next;
			halted_q       <= halt_next;
		end
	end

endmodule

// ----- src/b64d_outbuf.sv -----
module b64d_outbuf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  b64d_pkg::bundle_t bundle,
	output logic              can_load,
	output logic              res_valid,
	input  logic              res_ready,
	output b64d_pkg::out_t    res_data
);

	b64d_pkg::out_t [b64d_pkg::MaxResults-1:0] buf_q;
	logic [1:0]                                cnt_q;

	// Free now, or the last waiting word leaves at this edge.
	assign can_load  = (cnt_q == 2'd0) || (cnt_q == 2'd1 && res_ready);
	assign res_valid = (cnt_q != 2'd0);
	assign res_data  = buf_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (load && can_load) begin
			cnt_q <= bundle.count;
		end else if (res_valid && res_ready) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load && can_load) begin
			buf_q <= bundle.res;
		end else if (res_valid && res_ready) begin
			buf_q[0] <= buf_q[1];
			buf_q[1] <= buf_q[2];
		end
	end

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps

module tb;

	class decode_scoreboard;
		b64d_pkg::out_t pending_bytes[$];
		int unsigned    fails = 0;
		logic [1:0]     sextet_fill = 2'd0;
		logic [17:0]    sextet_buf = 18'd0;
		bit             stopped = 1'b0;

		function int sextet_of(logic [7:0] c);
			if (c >= "A" && c <= "Z") return int'(c) - int'("A");
			if (c >= "a" && c <= "z") return int'(c) - int'("a") + 26;
			if (c >= "0" && c <= "9") return int'(c) - int'("0") + 52;
			if (c == "+") return 62;
			if (c == "/") return 63;
			return -1;
		endfunction

		function b64d_pkg::out_t byte_word(logic [7:0] data, logic valid);
			b64d_pkg::out_t r;
			r.data_byte  = data;
			r.byte_valid = valid;
			r.run_last   = 1'b0;
			r.done_res   = 1'b0;
			return r;
		endfunction

		// Works out the result words one accepted character word causes.
		function void note_char(b64d_pkg::in_t w);
			int v;
			int n;
			logic [5:0] sx;
			logic [23:0] grp;
			b64d_pkg::out_t batch[$];
			v = sextet_of(w.symbol);
			sx = v[5:0];
			if (!stopped) begin
				if (v < 0) begin
					stopped = 1'b1;
				end else if (sextet_fill == 2'd3) begin
					grp = {sextet_buf, sx};
					batch = {batch, byte_word(grp[23:16], 1'b1)};
					batch = {batch, byte_word(grp[15:8], 1'b1)};
					batch = {batch, byte_word(grp[7:0], 1'b1)};
					sextet_fill = 2'd0;
					sextet_buf = '0;
				end else begin
					sextet_buf = {sextet_buf[11:0], sx};
					sextet_fill = sextet_fill + 2'd1;
				end
			end
			if (w.message_end) begin
				// Leftover bits that do not fill a whole byte are dropped.
				if (sextet_fill == 2'd2) begin
					batch = {batch, byte_word(sextet_buf[11:4], 1'b1)};
				end else if (sextet_fill == 2'd3) begin
					batch = {batch, byte_word(sextet_buf[17:10], 1'b1)};
					batch = {batch, byte_word(sextet_buf[9:2], 1'b1)};
				end
				if (batch.size() == 0)
					batch = {batch, byte_word(8'h00, 1'b0)};
				n = batch.size();
				batch[n-1].done_res = 1'b1;
				sextet_fill = 2'd0;
				sextet_buf = '0;
				stopped = 1'b0;
			end
			n = batch.size();
			if (n != 0)
				batch[n-1].run_last = 1'b1;
			foreach (batch[i])
				pending_bytes = {pending_bytes, batch[i]};
		endfunction

		function void check_byte(b64d_pkg::out_t got);
			b64d_pkg::out_t want;
			if (pending_bytes.size() == 0) begin
				$error("unexpected result word %h", got);
				fails++;
				return;
			end
			want = pending_bytes.pop_front();
			if (got.data_byte !== want.data_byte) begin
				$error("data_byte: expected %0h, got %0h", want.data_byte, got.data_byte);
				fails++;
			end
			if (got.byte_valid !== want.byte_valid) begin
				$error("byte_valid: expected %0b, got %0b", want.byte_valid, got.byte_valid);
				fails++;
			end
			if (got.run_last !== want.run_last) begin
				$error("run_last: expected %0b, got %0b", want.run_last, got.run_last);
				fails++;
			end
			if (got.done_res !== want.done_res) begin
				$error("done_res: expected %0b, got %0b", want.done_res, got.done_res);
				fails++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic char_valid = 1'b0;
	logic char_ready;
	b64d_pkg::in_t  char_data = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	b64d_pkg::out_t res_data;

	decode_scoreboard sb = new();

	logic [7:0] text[$];
	bit idle_en = 1'b1;
	bit hold_req = 1'b0;
	int unsigned sent_chars = 0;

	base64_decoder_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.char_valid(char_valid),
		.char_ready(char_ready),
		.char_data (char_data),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (char_valid && char_ready)
				sb.note_char(char_data);
			if (res_valid && res_ready)
				sb.check_byte(res_data);
		end
	end

	// Receiver: random stall bursts, plus one long hold-off on request.
	initial begin
		forever begin
			if (hold_req) begin
				res_ready <= 1'b0;
				repeat (300) @(posedge clk);
				hold_req = 1'b0;
			end else if (idle_en && $urandom_range(0, 5) == 0) begin
				res_ready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end else begin
				res_ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	initial begin
		#2000000;
		$display("FAILURE");
		$finish;
	end

	function logic [7:0] alpha_char(int v);
		if (v < 26) return 8'(int'("A") + v);
		if (v < 52) return 8'(int'("a") + v - 26);
		if (v < 62) return 8'(int'("0") + v - 52);
		if (v == 62) return "+";
		return "/";
	endfunction

	function void push_str(string s);
		for (int i = 0; i < s.len(); i++)
			text = {text, s[i]};
	endfunction

	task automatic send_word(b64d_pkg::in_t w);
		if (idle_en && $urandom_range(0, 3) == 0) begin
			char_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		char_valid <= 1'b1;
		char_data <= w;
		@(posedge clk);
		while (!char_ready) @(posedge clk);
	endtask

	// Sends the collected text as one message and empties it.
	task automatic send_text();
		b64d_pkg::in_t w;
		for (int i = 0; i < text.size(); i++) begin
			w.symbol = text[i];
			w.message_end = (i == text.size() - 1);
			sent_chars++;
			send_word(w);
		end
		text.delete();
	endtask

	initial begin
		int kind;
		int len;
		int pos;
		bit pressed;
		pressed = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed messages.
		push_str("TWFu");
		send_text();
		push_str("A");
		send_text();
		push_str("//8=");
		send_text();
		push_str("Zg==");
		send_text();
		text = {text, 8'h00};
		text = {text, 8'hFF};
		push_str("Q");
		send_text();
		text = {text, 8'h80};
		send_text();
		push_str("/+aZ09");
		send_text();

		// Random messages: mostly well formed, some broken, some noise.
		while (sent_chars < 250) begin
			if (!pressed && sent_chars > 60) begin
				hold_req = 1'b1;
				pressed = 1'b1;
			end
			if (sent_chars > 210)
				idle_en = 1'b0;
			kind = $urandom_range(0, 9);
			len = $urandom_range(1, 14);
			if (kind >= 8) begin
				for (int i = 0; i < len; i++)
					text = {text, 8'($urandom_range(0, 255))};
			end else begin
				for (int i = 0; i < len; i++)
					text = {text, alpha_char($urandom_range(0, 63))};
				if (kind >= 6) begin
					pos = $urandom_range(0, len - 1);
					text[pos] = 8'($urandom_range(0, 255));
				end
				if (len % 4 != 0 && $urandom_range(0, 1) == 1) begin
					while (text.size() % 4 != 0)
						text = {text, 8'h3D};
				end
			end
			send_text();
		end
		char_valid <= 1'b0;

		while (sb.pending_bytes.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.pending_bytes.size() != 0) begin
			$error("%0d result words never arrived", sb.pending_bytes.size());
			sb.fails++;
		end
		if (sb.fails == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end
endmodule
